[design/sdeq_pkg.sv]
// Package for the sorted double-ended queue.
// Holds sizes, operation and status codes, and the cell control struct.
// No dependencies.
`timescale 1ns / 1ps

package sdeq_pkg;

   localparam int CAPACITY = 16;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int DATA_W   = 32;

   localparam logic [1:0] OP_INSERT     = 2'd0;
   localparam logic [1:0] OP_POP_FIRST  = 2'd1;
   localparam logic [1:0] OP_POP_LAST   = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic [DATA_W-1:0] MOST_NEGATIVE = {1'b1, {(DATA_W-1){1'b0}}};

   typedef struct packed {
      logic              insert;
      logic              pop_first;
      logic [DATA_W-1:0] value;
   } ctl_type;

endpackage

[design/sorted_double_ended_queue.sv]
// Top level of the sorted double-ended queue: cell row, count and response register.
// Depends on sdeq_pkg and sdeq_cell.
// The response is registered and appears in the cycle after the request is accepted;
// the block takes one request per cycle while rsp_ready is high.
// Reset clears the entry count and the response valid; cell entries are not reset.
`timescale 1ns / 1ps

module sorted_double_ended_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_operation,
   input  logic signed [sdeq_pkg::DATA_W-1:0]  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [sdeq_pkg::DATA_W-1:0]  rsp_result_value,
   output logic [1:0]                          rsp_status
);

   logic [sdeq_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [sdeq_pkg::DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]                         rsp_status_ff, rsp_status_in;
   logic                               req_accept;
   logic                               is_full, is_empty;
   logic [sdeq_pkg::IDX_W-1:0]         last_idx;
   logic [sdeq_pkg::COUNT_W-1:0]       count_dec;
   sdeq_pkg::ctl_type                  ctl;

   logic signed [sdeq_pkg::DATA_W-1:0] entry [sdeq_pkg::CAPACITY];
   logic                               keep  [sdeq_pkg::CAPACITY];

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign is_full    = (count_ff == sdeq_pkg::COUNT_W'(sdeq_pkg::CAPACITY));
   assign is_empty   = (count_ff == '0);
   assign count_dec  = count_ff - sdeq_pkg::COUNT_W'(1);
   assign last_idx   = count_dec[sdeq_pkg::IDX_W-1:0];

   assign ctl.insert    = req_accept && (req_operation == sdeq_pkg::OP_INSERT) && !is_full;
   assign ctl.pop_first = req_accept && (req_operation == sdeq_pkg::OP_POP_FIRST) && !is_empty;
   assign ctl.value     = req_value;

   for (genvar i = 0; i < sdeq_pkg::CAPACITY; i++) begin : g_cell
      logic                               occ;
      logic                               lk;
      logic signed [sdeq_pkg::DATA_W-1:0] le, re;

      assign occ = (count_ff > sdeq_pkg::COUNT_W'(i));
      if (i == 0) begin : g_first
         assign lk = 1'b1;
         assign le = req_value;
      end else begin : g_mid
         assign lk = keep[i-1];
         assign le = entry[i-1];
      end
      if (i == sdeq_pkg::CAPACITY - 1) begin : g_last
         assign re = entry[i];
      end else begin : g_inner
         assign re = entry[i+1];
      end

      sdeq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (occ),
         .left_keep   (lk),
         .left_entry  (le),
         .right_entry (re),
         .entry       (entry[i]),
         .keep        (keep[i])
      );
   end

   always_comb begin
      count_in      = count_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         case (req_operation)
            sdeq_pkg::OP_INSERT: begin
               rsp_value_in = req_value;
               if (is_full) begin
                  rsp_status_in = sdeq_pkg::STATUS_FULL;
               end else begin
                  rsp_status_in = sdeq_pkg::STATUS_OK;
                  count_in      = count_ff + sdeq_pkg::COUNT_W'(1);
               end
            end
            sdeq_pkg::OP_POP_FIRST, sdeq_pkg::OP_POP_LAST: begin
               if (is_empty) begin
                  rsp_value_in  = $signed(sdeq_pkg::MOST_NEGATIVE);
                  rsp_status_in = sdeq_pkg::STATUS_EMPTY;
               end else begin
                  rsp_value_in  = (req_operation == sdeq_pkg::OP_POP_FIRST) ?
                                  entry[0] : entry[last_idx];
                  rsp_status_in = sdeq_pkg::STATUS_OK;
                  count_in      = count_dec;
               end
            end
            default: begin
               rsp_value_in  = '0;
               rsp_status_in = sdeq_pkg::STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sdeq_pkg::COUNT_W'(sdeq_pkg::CAPACITY))
      else $error("entry count above capacity");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(count_ff))
      else $error("entry count changed without a request");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_operation == sdeq_pkg::OP_INSERT && is_full
      |=> rsp_status_ff == sdeq_pkg::STATUS_FULL && $stable(count_ff))
      else $error("insert into full store not dropped");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      req_accept && is_empty &&
      (req_operation == sdeq_pkg::OP_POP_FIRST || req_operation == sdeq_pkg::OP_POP_LAST)
      |=> rsp_status_ff == sdeq_pkg::STATUS_EMPTY &&
          rsp_value_ff == $signed(sdeq_pkg::MOST_NEGATIVE))
      else $error("pop from empty store returned wrong response");

endmodule

[design/sdeq_cell.sv]
// One storage cell of the sorted row; holds one entry.
// Takes the new value or left entry on insert and the right entry on pop-first.
// Depends on sdeq_pkg.
`timescale 1ns / 1ps

module sdeq_cell (
   input  logic                                clock,
   input  sdeq_pkg::ctl_type                   ctl,
   input  logic                                occupied,
   input  logic                                left_keep,
   input  logic signed [sdeq_pkg::DATA_W-1:0]  left_entry,
   input  logic signed [sdeq_pkg::DATA_W-1:0]  right_entry,
   output logic signed [sdeq_pkg::DATA_W-1:0]  entry,
   output logic                                keep
);

   logic signed [sdeq_pkg::DATA_W-1:0] entry_ff;
   logic signed [sdeq_pkg::DATA_W-1:0] entry_in;

   assign keep  = occupied && (entry_ff < $signed(ctl.value));
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (left_keep) begin
            entry_in = $signed(ctl.value);
         end else begin
            entry_in = left_entry;
         end
      end else if (ctl.pop_first) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

[verif/sdeq_order_checker.sv]
// Response checker for the sorted double-ended queue: mirrors the sorted store,
// predicts each response and compares it with what the block returns.
// Depends on sdeq_pkg.
`timescale 1ns / 1ps

module sdeq_order_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [1:0]                         req_operation,
   input  logic signed [sdeq_pkg::DATA_W-1:0] req_value,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic signed [sdeq_pkg::DATA_W-1:0] rsp_result_value,
   input  logic [1:0]                         rsp_status,
   output int                                 mismatch_count,
   output int                                 outstanding_count
);

   typedef struct {
      logic signed [sdeq_pkg::DATA_W-1:0] result_value;
      logic [1:0]                         status;
   } response_fields_type;

   logic signed [sdeq_pkg::DATA_W-1:0] sorted_store[$];
   response_fields_type                awaited_responses[$];

   // Apply one request to the mirrored store and return the response it yields.
   function automatic response_fields_type apply_request(
         input logic [1:0]                         op,
         input logic signed [sdeq_pkg::DATA_W-1:0] v);
      response_fields_type r;
      int slot;
      r.result_value = '0;
      r.status       = sdeq_pkg::STATUS_OK;
      case (op)
         sdeq_pkg::OP_INSERT: begin
            r.result_value = v;
            if (sorted_store.size() >= sdeq_pkg::CAPACITY) begin
               r.status = sdeq_pkg::STATUS_FULL;
            end else begin
               slot = 0;
               while (slot < sorted_store.size() && sorted_store[slot] < v) slot++;
               sorted_store.insert(slot, v);
            end
         end
         sdeq_pkg::OP_POP_FIRST, sdeq_pkg::OP_POP_LAST: begin
            if (sorted_store.size() == 0) begin
               r.result_value = sdeq_pkg::MOST_NEGATIVE;
               r.status       = sdeq_pkg::STATUS_EMPTY;
            end else if (op == sdeq_pkg::OP_POP_FIRST) begin
               r.result_value = sorted_store.pop_front();
            end else begin
               r.result_value = sorted_store.pop_back();
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   initial begin
      mismatch_count    = 0;
      outstanding_count = 0;
   end

   always @(posedge clock) begin
      response_fields_type want;
      int                  new_errors;
      new_errors = 0;
      if (reset) begin
         sorted_store.delete();
         awaited_responses.delete();
      end else begin
         if (req_valid && req_ready)
            awaited_responses.push_back(apply_request(req_operation, req_value));
         if (rsp_valid && rsp_ready) begin
            if (awaited_responses.size() == 0) begin
               $error("unexpected response: result_value %0d status %0d",
                      rsp_result_value, rsp_status);
               new_errors++;
            end else begin
               want = awaited_responses.pop_front();
               if (rsp_result_value !== want.result_value) begin
                  $error("result_value: expected %0d, actual %0d",
                         want.result_value, rsp_result_value);
                  new_errors++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  new_errors++;
               end
            end
         end
      end
      mismatch_count    <= mismatch_count + new_errors;
      outstanding_count <= awaited_responses.size();
   end

endmodule

[verif/tb_top.sv]
// Testbench top for the sorted double-ended queue: clock, reset, request and
// response stimulus with random idling, and the final verdict.
// Depends on sdeq_pkg, sorted_double_ended_queue and sdeq_order_checker.
`timescale 1ns / 1ps

module tb_top;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         ITEM_TARGET = 2000;
   localparam int         LONG_HOLD   = 250;
   localparam int         CYCLE_LIMIT = 500000;

   typedef enum {MIX_PHASE, FILL_PHASE, DRAIN_PHASE} phase_kind_type;

   logic                               clock;
   logic                               reset = 1'b1;
   logic                               req_valid;
   logic                               req_ready;
   logic [1:0]                         req_operation;
   logic signed [sdeq_pkg::DATA_W-1:0] req_value;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic signed [sdeq_pkg::DATA_W-1:0] rsp_result_value;
   logic [1:0]                         rsp_status;

   int   mismatch_count;
   int   outstanding_count;
   int   cycle_count = 0;
   bit   quiet_sender;
   bit   quiet_receiver;
   bit   hold_off_pending;

   sorted_double_ended_queue i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status)
   );

   sdeq_order_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_value  (rsp_result_value),
      .rsp_status        (rsp_status),
      .mismatch_count    (mismatch_count),
      .outstanding_count (outstanding_count)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[sorted_double_ended_queue] ERROR");
         $finish;
      end
   end

   function automatic logic [1:0] draw_operation(input phase_kind_type kind);
      int roll;
      int insert_pct;
      roll = $urandom_range(0, 99);
      case (kind)
         FILL_PHASE:  insert_pct = 80;
         DRAIN_PHASE: insert_pct = 20;
         default:     insert_pct = 48;
      endcase
      if (roll < insert_pct) return sdeq_pkg::OP_INSERT;
      if (roll >= 96) return OP_UNUSED;
      return (roll % 2 == 0) ? sdeq_pkg::OP_POP_FIRST : sdeq_pkg::OP_POP_LAST;
   endfunction

   function automatic logic signed [sdeq_pkg::DATA_W-1:0] draw_value();
      int near_zero;
      near_zero = $urandom_range(0, 8);
      case ($urandom_range(0, 3))
         0: return near_zero - 4;
         1: begin
            case ($urandom_range(0, 3))
               0:       return sdeq_pkg::MOST_NEGATIVE;
               1:       return ~sdeq_pkg::MOST_NEGATIVE;
               2:       return '0;
               default: return '1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(input logic [1:0] op,
                               input logic signed [sdeq_pkg::DATA_W-1:0] v);
      int gap;
      gap = quiet_sender ? 0 : $urandom_range(0, 13);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_operation <= op;
      req_value     <= v;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding_count != 0) @(posedge clock);
   endtask

   // Response side: random stall per response, plus one long hold-off on request.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_pending) begin
            repeat (LONG_HOLD) begin
               @(negedge clock);
               rsp_ready <= 1'b0;
            end
            hold_off_pending = 1'b0;
         end
         stall = quiet_receiver ? 0 : $urandom_range(0, 13);
         repeat (stall) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin
      int             sent;
      int             phase_no;
      int             phase_len;
      phase_kind_type kind;
      logic [1:0]     op;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = sdeq_pkg::OP_INSERT;
      req_value        = '0;
      quiet_sender     = 1'b0;
      quiet_receiver   = 1'b0;
      hold_off_pending = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // pops on an empty store, unused code, extremes, duplicates, then drain past empty
      send_request(sdeq_pkg::OP_POP_FIRST, 32'sd7);
      send_request(sdeq_pkg::OP_POP_LAST, -32'sd7);
      send_request(OP_UNUSED, '1);
      send_request(sdeq_pkg::OP_INSERT, ~sdeq_pkg::MOST_NEGATIVE);
      send_request(sdeq_pkg::OP_INSERT, sdeq_pkg::MOST_NEGATIVE);
      send_request(sdeq_pkg::OP_INSERT, '0);
      send_request(sdeq_pkg::OP_INSERT, -32'sd1);
      send_request(sdeq_pkg::OP_INSERT, 32'sd1);
      send_request(sdeq_pkg::OP_INSERT, 32'sd1);
      send_request(sdeq_pkg::OP_INSERT, sdeq_pkg::MOST_NEGATIVE);
      send_request(sdeq_pkg::OP_POP_FIRST, '0);
      send_request(sdeq_pkg::OP_POP_LAST, '1);
      send_request(sdeq_pkg::OP_POP_FIRST, '0);
      send_request(sdeq_pkg::OP_POP_LAST, '0);
      send_request(sdeq_pkg::OP_POP_FIRST, '0);
      send_request(sdeq_pkg::OP_POP_LAST, '0);
      send_request(sdeq_pkg::OP_POP_FIRST, '0);
      send_request(sdeq_pkg::OP_POP_LAST, '0);
      send_request(OP_UNUSED, '0);
      drain_responses();

      sent     = 0;
      phase_no = 0;
      while (sent < ITEM_TARGET) begin
         kind           = phase_kind_type'($urandom_range(0, 2));
         phase_len      = $urandom_range(10, 60);
         quiet_sender   = ($urandom_range(0, 3) == 0);
         quiet_receiver = ($urandom_range(0, 3) == 0);
         if (phase_no == 0) begin
            kind      = FILL_PHASE;
            phase_len = 45;
         end else if (phase_no == 1) begin
            kind      = DRAIN_PHASE;
            phase_len = 45;
         end else if (phase_no == 6) begin
            hold_off_pending = 1'b1;
            quiet_sender     = 1'b1;
            phase_len        = 40;
         end
         repeat (phase_len) begin
            op = draw_operation(kind);
            send_request(op, draw_value());
            if (op != OP_UNUSED) sent++;
         end
         if (phase_no % 8 == 7) drain_responses();
         phase_no++;
      end

      drain_responses();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && outstanding_count == 0) begin
         $display("[sorted_double_ended_queue] OK");
      end else begin
         $display("[sorted_double_ended_queue] ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
design/sdeq_pkg.sv
design/sdeq_cell.sv
design/sorted_double_ended_queue.sv
verif/sdeq_order_checker.sv
verif/tb_top.sv
